[rtl/link_staleness_monitor_macros.svh]
// Assertion macros for the link staleness monitor.
`ifndef LINK_STALENESS_MONITOR_MACROS_SVH
`define LINK_STALENESS_MONITOR_MACROS_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define LSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante, outside reset.
`define LSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lsm_pkg.sv]
// Shared codes and widths for the link staleness monitor.
package lsm_pkg;

    localparam int CMD_W     = 3;
    localparam int TYPE_W    = 8;
    localparam int TIME_W    = 32;
    localparam int COUNT_W   = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int STATE_W   = 2;

    // Event codes
    localparam logic [CMD_W-1:0] CMD_PROCESSING  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MSG_VALID   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MSG_ERROR   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LINK_UP     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LINK_LOST   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ACTIVITY    = 3'd5;
    localparam logic [CMD_W-1:0] CMD_STALE_CHECK = 3'd6;
    localparam logic [CMD_W-1:0] CMD_CONFIG_SENT = 3'd7;

    // Link states
    localparam logic [STATE_W-1:0] LINK_DISCONNECTED = 2'd0;
    localparam logic [STATE_W-1:0] LINK_CONNECTED    = 2'd1;
    localparam logic [STATE_W-1:0] LINK_ACTIVE       = 2'd2;
    localparam logic [STATE_W-1:0] LINK_STALE        = 2'd3;

    // Message states
    localparam logic [STATE_W-1:0] MSG_IDLE       = 2'd0;
    localparam logic [STATE_W-1:0] MSG_PROCESSING = 2'd1;
    localparam logic [STATE_W-1:0] MSG_VALID      = 2'd2;
    localparam logic [STATE_W-1:0] MSG_ERROR      = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STALE_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRACE_WINDOW  = 1'd1;

    localparam logic [CFG_W-1:0] STALE_TIMEOUT_RST = 16'd1000;
    localparam logic [CFG_W-1:0] GRACE_WINDOW_RST  = 16'd0;

endpackage

[rtl/link_staleness_monitor.sv]
// Top level of the link staleness monitor: event decode, status state and handshakes.
`include "link_staleness_monitor_macros.svh"

// Link staleness monitor. Each input beat carries one receiver event (cmd) with the
// current millisecond time (now_ms); each beat yields exactly one output beat, a full
// status snapshot taken after the event is applied. The block takes one beat per clock
// cycle while the output is taken. A beat is captured into the input register at its
// accepting edge and applied once the output side can take a new result, which loads
// the status registers and raises output valid. The snapshot is driven straight from
// the status registers, which change only when a new result is loaded, so a stalled
// output beat holds without a separate copy; while it stalls the input register
// still takes one more beat, then input ready drops until the output is taken. A
// stale check compares the age of the last activity (now_ms minus activity time,
// mod 2^32) against stale_timeout, extended by the unused part of grace_window after
// a config update; a recorded time of zero reads as never. Write configuration only
// while the block is idle.
module link_staleness_monitor (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [lsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lsm_pkg::CFG_W-1:0]     cfg_data,
    // event input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lsm_pkg::CMD_W-1:0]     s_cmd,
    input  logic [lsm_pkg::TYPE_W-1:0]    s_msg_code,
    input  logic [lsm_pkg::COUNT_W-1:0]   s_seq_number,
    input  logic [lsm_pkg::TIME_W-1:0]    s_now_ms,
    // status output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lsm_pkg::STATE_W-1:0]   m_link_state,
    output logic [lsm_pkg::STATE_W-1:0]   m_msg_status,
    output logic [lsm_pkg::TYPE_W-1:0]    m_last_type,
    output logic [lsm_pkg::COUNT_W-1:0]   m_last_seq,
    output logic [lsm_pkg::COUNT_W-1:0]   m_total_count,
    output logic [lsm_pkg::COUNT_W-1:0]   m_valid_count,
    output logic [lsm_pkg::COUNT_W-1:0]   m_error_count,
    output logic [lsm_pkg::COUNT_W-1:0]   m_stale_count
);
    import lsm_pkg::*;

    // Configuration
    logic [CFG_W-1:0]   stale_timeout_reg;
    logic [CFG_W-1:0]   grace_window_reg;

    // Input stage
    logic               in_valid_reg;
    logic [CMD_W-1:0]   in_cmd_reg;
    logic [TYPE_W-1:0]  in_type_reg;
    logic [COUNT_W-1:0] in_seq_reg;
    logic [TIME_W-1:0]  in_now_reg;

    // Status state, which is also the output snapshot
    logic               m_valid_reg;
    logic [STATE_W-1:0] link_reg,      link_next;
    logic [STATE_W-1:0] msg_reg,       msg_next;
    logic [TYPE_W-1:0]  type_reg,      type_next;
    logic [COUNT_W-1:0] seq_reg,       seq_next;
    logic [COUNT_W-1:0] total_reg,     total_next;
    logic [COUNT_W-1:0] valid_reg,     valid_next;
    logic [COUNT_W-1:0] error_reg,     error_next;
    logic [COUNT_W-1:0] stale_reg,     stale_next;
    logic [TIME_W-1:0]  activity_reg,  activity_next;
    logic [TIME_W-1:0]  config_reg,    config_next;

    // Stale check datapath
    logic [TIME_W-1:0]  since_cfg;
    logic [TIME_W-1:0]  age;
    logic               grace_on;
    logic [CFG_W-1:0]   grace_left;
    logic [CFG_W:0]     limit;
    logic               stale_hit;

    logic advance;   // output side can take a new result
    logic update;    // apply the event held in the input stage

    assign advance = !m_valid_reg || m_ready;
    assign update  = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stale_timeout_reg <= STALE_TIMEOUT_RST;
            grace_window_reg  <= GRACE_WINDOW_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_STALE_TIMEOUT: stale_timeout_reg <= cfg_data;
                REG_GRACE_WINDOW:  grace_window_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: load on every accepted beat, drain when the update fires
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg  <= s_cmd;
            in_type_reg <= s_msg_code;
            in_seq_reg  <= s_seq_number;
            in_now_reg  <= s_now_ms;
        end
    end

    // Grace extension: the window is active while a config time is recorded and
    // since_cfg < grace_window; the unused part fits in 16 bits, so the limit needs 17.
    assign since_cfg  = in_now_reg - config_reg;
    assign grace_on   = (grace_window_reg != '0) && (config_reg != '0) &&
                        (since_cfg < {{(TIME_W-CFG_W){1'b0}}, grace_window_reg});
    assign grace_left = grace_on ? (grace_window_reg - since_cfg[CFG_W-1:0]) : '0;
    assign limit      = {1'b0, stale_timeout_reg} + {1'b0, grace_left};
    assign age        = in_now_reg - activity_reg;
    assign stale_hit  = (link_reg == LINK_ACTIVE) && (activity_reg != '0) &&
                        (age > {{(TIME_W-CFG_W-1){1'b0}}, limit});

    // Event decode
    always_comb begin
        link_next     = link_reg;
        msg_next      = msg_reg;
        type_next     = type_reg;
        seq_next      = seq_reg;
        total_next    = total_reg;
        valid_next    = valid_reg;
        error_next    = error_reg;
        stale_next    = stale_reg;
        activity_next = activity_reg;
        config_next   = config_reg;
        unique case (in_cmd_reg)
            CMD_PROCESSING: begin
                msg_next   = MSG_PROCESSING;
                type_next  = in_type_reg;
                seq_next   = in_seq_reg;
                total_next = total_reg + COUNT_W'(1);
            end
            CMD_MSG_VALID: begin
                msg_next   = MSG_VALID;
                valid_next = valid_reg + COUNT_W'(1);
            end
            CMD_MSG_ERROR: begin
                msg_next   = MSG_ERROR;
                error_next = error_reg + COUNT_W'(1);
            end
            CMD_LINK_UP: begin
                link_next     = LINK_CONNECTED;
                activity_next = in_now_reg;
            end
            CMD_LINK_LOST: begin
                link_next = LINK_DISCONNECTED;
                msg_next  = MSG_IDLE;
            end
            CMD_ACTIVITY: begin
                // any link state goes active, disconnected included
                link_next     = LINK_ACTIVE;
                activity_next = in_now_reg;
            end
            CMD_STALE_CHECK: begin
                if (stale_hit) begin
                    link_next  = LINK_STALE;
                    stale_next = stale_reg + COUNT_W'(1);
                end
            end
            CMD_CONFIG_SENT: begin
                config_next = in_now_reg;
            end
            default: ;
        endcase
    end

    // Status registers: advance only with a new result, so they hold a stalled beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            link_reg     <= LINK_DISCONNECTED;
            msg_reg      <= MSG_IDLE;
            type_reg     <= '0;
            seq_reg      <= '0;
            total_reg    <= '0;
            valid_reg    <= '0;
            error_reg    <= '0;
            stale_reg    <= '0;
            activity_reg <= '0;
            config_reg   <= '0;
        end else begin
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
            if (update) begin
                link_reg     <= link_next;
                msg_reg      <= msg_next;
                type_reg     <= type_next;
                seq_reg      <= seq_next;
                total_reg    <= total_next;
                valid_reg    <= valid_next;
                error_reg    <= error_next;
                stale_reg    <= stale_next;
                activity_reg <= activity_next;
                config_reg   <= config_next;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_link_state    = link_reg;
    assign m_msg_status    = msg_reg;
    assign m_last_type     = type_reg;
    assign m_last_seq      = seq_reg;
    assign m_total_count   = total_reg;
    assign m_valid_count   = valid_reg;
    assign m_error_count   = error_reg;
    assign m_stale_count   = stale_reg;

    // Every applied event shows up as an output beat next cycle
    `LSM_ASSERT_NEXT(a_update_gives_beat, update, m_valid_reg, "applied event produced no output beat")
    // Only a stale check may move the stale counter
    `LSM_ASSERT_NEXT(a_stale_count_only_on_check, update && (in_cmd_reg != CMD_STALE_CHECK), $stable(stale_reg), "stale count moved outside a stale check")
    // A stale check leaves a link that is not active alone
    `LSM_ASSERT_NEXT(a_check_needs_active, update && (in_cmd_reg == CMD_STALE_CHECK) && (link_reg != LINK_ACTIVE), $stable(link_reg) && $stable(stale_reg), "stale check changed a link that was not active")
    // An empty input stage always takes a beat
    `LSM_ASSERT_NOW(a_empty_input_ready, !in_valid_reg, s_ready, "input stage empty but not ready")

endmodule

[verif/link_staleness_monitor_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the link staleness monitor: directed and random events.
module link_staleness_monitor_tb;
    import lsm_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 4;          // input and status registers plus margin
    localparam int MAX_WAIT      = 14;
    localparam int HOLD_CYCLES   = 80;
    localparam int PHASES        = 8;
    localparam int PHASE_BEATS   = 190;
    localparam int TIMEOUT_NS    = 5_000_000;  // about 10x the slowest clean run

    // One input beat: an event stamped with the millisecond time.
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [TYPE_W-1:0]  msg_code;
        logic [COUNT_W-1:0] seq_number;
        logic [TIME_W-1:0]  now_ms;
    } event_beat_t;

    // One output beat: the full status snapshot after the event.
    typedef struct packed {
        logic [STATE_W-1:0] link_state;
        logic [STATE_W-1:0] msg_status;
        logic [TYPE_W-1:0]  last_type;
        logic [COUNT_W-1:0] last_seq;
        logic [COUNT_W-1:0] total_count;
        logic [COUNT_W-1:0] valid_count;
        logic [COUNT_W-1:0] error_count;
        logic [COUNT_W-1:0] stale_count;
    } status_t;

    // How often a side idles between beats.
    typedef enum {PACE_FULL, PACE_LIGHT, PACE_HEAVY} pace_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_cmd;
    logic [TYPE_W-1:0]    s_msg_code;
    logic [COUNT_W-1:0]   s_seq_number;
    logic [TIME_W-1:0]    s_now_ms;
    logic                 m_valid;
    logic                 m_ready;
    logic [STATE_W-1:0]   m_link_state;
    logic [STATE_W-1:0]   m_msg_status;
    logic [TYPE_W-1:0]    m_last_type;
    logic [COUNT_W-1:0]   m_last_seq;
    logic [COUNT_W-1:0]   m_total_count;
    logic [COUNT_W-1:0]   m_valid_count;
    logic [COUNT_W-1:0]   m_error_count;
    logic [COUNT_W-1:0]   m_stale_count;

    // Predicted monitor state and configuration.
    status_t           model_status;
    logic [TIME_W-1:0] activity_ms;
    logic [TIME_W-1:0] config_ms;
    logic [CFG_W-1:0]  timeout_ms;
    logic [CFG_W-1:0]  grace_ms;

    // Snapshots owed by the block, oldest first.
    status_t pending_snapshots[$];

    int                mismatches      = 0;
    int                beats_sent      = 0;
    int                recv_stall_left = 0;
    int                recv_hold_left  = 0;
    pace_t             send_pace       = PACE_LIGHT;
    pace_t             recv_pace       = PACE_LIGHT;
    logic [TIME_W-1:0] clock_ms        = '0;

    link_staleness_monitor dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_msg_code      (s_msg_code),
        .s_seq_number    (s_seq_number),
        .s_now_ms        (s_now_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_link_state    (m_link_state),
        .m_msg_status    (m_msg_status),
        .m_last_type     (m_last_type),
        .m_last_seq      (m_last_seq),
        .m_total_count   (m_total_count),
        .m_valid_count   (m_valid_count),
        .m_error_count   (m_error_count),
        .m_stale_count   (m_stale_count)
    );

    initial begin
        aclk = 1'b0;
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // Apply one accepted event to the predicted state; return the snapshot it yields.
    function automatic status_t update_status(input event_beat_t ev);
        logic [TIME_W-1:0] limit;
        logic [TIME_W-1:0] since_cfg;
        logic [TIME_W-1:0] age;
        case (ev.cmd)
            CMD_PROCESSING: begin
                model_status.msg_status  = MSG_PROCESSING;
                model_status.last_type   = ev.msg_code;
                model_status.last_seq    = ev.seq_number;
                model_status.total_count = model_status.total_count + COUNT_W'(1);
            end
            CMD_MSG_VALID: begin
                model_status.msg_status  = MSG_VALID;
                model_status.valid_count = model_status.valid_count + COUNT_W'(1);
            end
            CMD_MSG_ERROR: begin
                model_status.msg_status  = MSG_ERROR;
                model_status.error_count = model_status.error_count + COUNT_W'(1);
            end
            CMD_LINK_UP: begin
                model_status.link_state = LINK_CONNECTED;
                activity_ms             = ev.now_ms;
            end
            CMD_LINK_LOST: begin
                model_status.link_state = LINK_DISCONNECTED;
                model_status.msg_status = MSG_IDLE;
            end
            CMD_ACTIVITY: begin
                model_status.link_state = LINK_ACTIVE;
                activity_ms             = ev.now_ms;
            end
            CMD_STALE_CHECK: begin
                // A zero activity stamp means never, so the check is skipped.
                if (model_status.link_state == LINK_ACTIVE && activity_ms != '0) begin
                    limit     = TIME_W'(timeout_ms);
                    since_cfg = ev.now_ms - config_ms;
                    // Extend by the unused part of the grace window after a config update.
                    if (grace_ms != '0 && config_ms != '0 && since_cfg < TIME_W'(grace_ms))
                        limit = limit + TIME_W'(grace_ms) - since_cfg;
                    age = ev.now_ms - activity_ms;
                    if (age > limit) begin
                        model_status.link_state  = LINK_STALE;
                        model_status.stale_count = model_status.stale_count + COUNT_W'(1);
                    end
                end
            end
            CMD_CONFIG_SENT: config_ms = ev.now_ms;
            default: ;
        endcase
        return model_status;
    endfunction

    function automatic int draw_wait(input pace_t pace);
        case (pace)
            PACE_FULL:  return 0;
            PACE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
            default:    return $urandom_range(0, MAX_WAIT);
        endcase
    endfunction

    function automatic event_beat_t make_beat(input logic [CMD_W-1:0] cmd,
                                              input logic [TYPE_W-1:0] msg_code,
                                              input logic [COUNT_W-1:0] seq_number,
                                              input logic [TIME_W-1:0] now_ms);
        event_beat_t ev;
        ev.cmd        = cmd;
        ev.msg_code   = msg_code;
        ev.seq_number = seq_number;
        ev.now_ms     = now_ms;
        return ev;
    endfunction

    // Advance the free-running time; now and then jump, go near the wrap, or read zero.
    function automatic logic [TIME_W-1:0] next_now();
        case ($urandom_range(0, 15))
            0:          clock_ms = $urandom();
            1:          clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
            2:          return '0;
            3, 4, 5, 6: clock_ms = clock_ms + $urandom_range(0, 40);
            7, 8, 9:    clock_ms = clock_ms + $urandom_range(0, 1500);
            default:    clock_ms = clock_ms + $urandom_range(0, 140000);
        endcase
        return clock_ms;
    endfunction

    // Aim a stale check at the edge of the timeout or inside the grace zone.
    function automatic logic [TIME_W-1:0] near_deadline();
        if ($urandom_range(0, 1))
            clock_ms = activity_ms + TIME_W'(timeout_ms) + $urandom_range(0, 4) - 32'd2;
        else
            clock_ms = activity_ms + TIME_W'(timeout_ms) +
                       $urandom_range(0, int'(grace_ms) + 2);
        return clock_ms;
    endfunction

    function automatic logic [CFG_W-1:0] pick_setting();
        case ($urandom_range(0, 3))
            0:       return CFG_W'($urandom_range(0, 64));
            1:       return CFG_W'($urandom_range(0, 2000));
            2:       return CFG_W'($urandom_range(0, 65535));
            default: return '0;
        endcase
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endfunction

    // Offer one beat after a random gap and hold it until accepted. Start and end at a
    // falling edge; leave valid high so a back-to-back beat keeps it up.
    task automatic send_event(input event_beat_t ev);
        int gap;
        gap = draw_wait(send_pace);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_cmd        = ev.cmd;
        s_msg_code   = ev.msg_code;
        s_seq_number = ev.seq_number;
        s_now_ms     = ev.now_ms;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_snapshots.push_back(update_status(ev));
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now_ms);
        send_event(make_beat(cmd, TYPE_W'($urandom_range(0, 255)), $urandom(), now_ms));
    endtask

    // Drop valid, wait for every owed snapshot, then let the pipeline settle.
    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending_snapshots.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (index)
            REG_STALE_TIMEOUT: timeout_ms = value;
            REG_GRACE_WINDOW:  grace_ms   = value;
            default: ;
        endcase
    endtask

    // Reconfigure only once the block has gone idle.
    task automatic write_config(input logic [CFG_W-1:0] timeout, input logic [CFG_W-1:0] grace);
        wait_idle();
        write_register(REG_STALE_TIMEOUT, timeout);
        write_register(REG_GRACE_WINDOW, grace);
    endtask

    // A well-formed link session: come up, go active, exchange messages and checks.
    task automatic run_session(input int length);
        int pick;
        send_cmd(CMD_LINK_UP, next_now());
        send_cmd(CMD_ACTIVITY, next_now());
        repeat (length) begin
            pick = $urandom_range(0, 15);
            case (pick)
                0, 1, 2, 3, 4: begin
                    send_cmd(CMD_PROCESSING, next_now());
                    send_cmd(pick[0] ? CMD_MSG_VALID : CMD_MSG_ERROR, next_now());
                end
                5, 6, 7:   send_cmd(CMD_ACTIVITY, next_now());
                8, 9, 10:  send_cmd(CMD_STALE_CHECK, near_deadline());
                11, 12:    send_cmd(CMD_STALE_CHECK, next_now());
                13:        send_cmd(CMD_CONFIG_SENT, next_now());
                14:        send_cmd(CMD_LINK_UP, next_now());
                default:   send_cmd(CMD_PROCESSING, next_now());
            endcase
        end
        if ($urandom_range(0, 1))
            send_cmd(CMD_LINK_LOST, next_now());
    endtask

    // Message events with extreme type, sequence and time values.
    task automatic test_message_events();
        send_event(make_beat(CMD_PROCESSING, 8'hFF, 32'hFFFF_FFFF, 32'd0));
        send_event(make_beat(CMD_MSG_VALID, 8'h00, 32'd0, 32'd1));
        send_event(make_beat(CMD_MSG_ERROR, 8'h00, 32'd0, 32'd2));
        send_event(make_beat(CMD_PROCESSING, 8'h00, 32'd0, 32'hFFFF_FFFF));
        send_event(make_beat(CMD_MSG_VALID, 8'hA5, 32'h5A5A_5A5A, 32'd3));
        send_event(make_beat(CMD_LINK_LOST, 8'h00, 32'd0, 32'd4));
    endtask

    // Link transitions: activity from disconnected, zero stamp, timeout edge, repeat check.
    task automatic test_link_events();
        send_event(make_beat(CMD_ACTIVITY, 8'h00, 32'd0, 32'd0));
        send_event(make_beat(CMD_STALE_CHECK, 8'h00, 32'd0, 32'hFFFF_FFFF));
        send_event(make_beat(CMD_LINK_UP, 8'h00, 32'd0, 32'd100));
        send_event(make_beat(CMD_ACTIVITY, 8'h00, 32'd0, 32'd200));
        send_event(make_beat(CMD_STALE_CHECK, 8'h00, 32'd0, 32'd1200));
        send_event(make_beat(CMD_STALE_CHECK, 8'h00, 32'd0, 32'd1201));
        send_event(make_beat(CMD_STALE_CHECK, 8'h00, 32'd0, 32'd9000));
    endtask

    // Grace extension: blocked by a zero config stamp, then held and crossed at its edge.
    task automatic test_grace_window();
        write_config(16'd10, 16'd100);
        send_event(make_beat(CMD_CONFIG_SENT, 8'h00, 32'd0, 32'd0));
        send_event(make_beat(CMD_ACTIVITY, 8'h00, 32'd0, 32'd50));
        send_event(make_beat(CMD_STALE_CHECK, 8'h00, 32'd0, 32'd200));
        send_event(make_beat(CMD_ACTIVITY, 8'h00, 32'd0, 32'd2000));
        send_event(make_beat(CMD_CONFIG_SENT, 8'h00, 32'd0, 32'd2000));
        send_event(make_beat(CMD_STALE_CHECK, 8'h00, 32'd0, 32'd2055));
        send_event(make_beat(CMD_STALE_CHECK, 8'h00, 32'd0, 32'd2056));
    endtask

    // Largest and zero settings, with ages that wrap past 2^32.
    task automatic test_timeout_extremes();
        logic [TIME_W-1:0] base;
        base = 32'hFFFF_FFF0;
        write_config(16'hFFFF, 16'hFFFF);
        send_event(make_beat(CMD_ACTIVITY, 8'h00, 32'd0, base));
        send_event(make_beat(CMD_CONFIG_SENT, 8'h00, 32'd0, base));
        send_event(make_beat(CMD_STALE_CHECK, 8'h00, 32'd0, base + 32'd65534));
        send_event(make_beat(CMD_STALE_CHECK, 8'h00, 32'd0, base + 32'd65536));
        write_config(16'd0, 16'd0);
        send_event(make_beat(CMD_ACTIVITY, 8'h00, 32'd0, 32'd5));
        send_event(make_beat(CMD_STALE_CHECK, 8'h00, 32'd0, 32'd5));
        send_event(make_beat(CMD_STALE_CHECK, 8'h00, 32'd0, 32'd6));
    endtask

    // Hold the output off for a long stretch while input beats keep coming at full rate,
    // so the block fills and has to stall its input.
    task automatic test_backpressure();
        wait_idle();
        send_pace      = PACE_FULL;
        recv_hold_left = HOLD_CYCLES;
        repeat (3) run_session(12);
    endtask

    // Random phases, each under its own settings and pacing: mostly sessions, some noise.
    task automatic test_random_traffic();
        int target;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       write_config('0, '0);
                1:       write_config('1, '1);
                2:       write_config(STALE_TIMEOUT_RST, GRACE_WINDOW_RST);
                default: write_config(pick_setting(), pick_setting());
            endcase
            send_pace = pace_t'(phase % 3);
            recv_pace = pace_t'($urandom_range(0, 2));
            target    = beats_sent + PHASE_BEATS;
            while (beats_sent < target) begin
                if ($urandom_range(0, 9) < 8)
                    run_session($urandom_range(2, 20));
                else
                    repeat ($urandom_range(1, 5))
                        send_cmd(CMD_W'($urandom_range(0, 7)), $urandom());
            end
        end
    endtask

    // Result side: take a beat, compare it with the oldest owed snapshot, draw the next stall.
    always @(posedge aclk) begin : check_beat
        status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_snapshots.size() == 0) begin
                $error("status beat with no event outstanding");
                mismatches++;
            end else begin
                want = pending_snapshots.pop_front();
                check_field("link_state", 32'(want.link_state), 32'(m_link_state));
                check_field("msg_status", 32'(want.msg_status), 32'(m_msg_status));
                check_field("last_type", 32'(want.last_type), 32'(m_last_type));
                check_field("last_seq", want.last_seq, m_last_seq);
                check_field("total_count", want.total_count, m_total_count);
                check_field("valid_count", want.valid_count, m_valid_count);
                check_field("error_count", want.error_count, m_error_count);
                check_field("stale_count", want.stale_count, m_stale_count);
            end
            recv_stall_left = draw_wait(recv_pace);
        end
    end

    // Drive ready at the falling edge; a long hold-off wins over the per-beat stall.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (recv_hold_left > 0) begin
                m_ready = 1'b0;
                recv_hold_left--;
            end else if (recv_stall_left > 0) begin
                m_ready = 1'b0;
                recv_stall_left--;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    initial begin
        #TIMEOUT_NS;
        $display("link_staleness_monitor_tb: done, errors");
        $finish;
    end

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_cmd        = '0;
        s_msg_code   = '0;
        s_seq_number = '0;
        s_now_ms     = '0;
        // Reset state: link disconnected, message idle, all counters and stamps zero.
        model_status = '0;
        activity_ms  = '0;
        config_ms    = '0;
        timeout_ms   = STALE_TIMEOUT_RST;
        grace_ms     = GRACE_WINDOW_RST;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_message_events();
        test_link_events();
        test_grace_window();
        test_timeout_extremes();
        test_backpressure();
        test_random_traffic();
        wait_idle();

        if (mismatches == 0)
            $display("link_staleness_monitor_tb: done, clean");
        else
            $display("link_staleness_monitor_tb: done, errors");
        $finish;
    end

endmodule
